// ----- src/sorted_priority_queue_macros.svh -----
// Assertion helpers for the sorted priority queue.
// Each check samples on the rising edge of clk and is off while rst_n is low.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define SPQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_priority_queue: same-cycle check failed");
// Next-cycle implication
`define SPQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_priority_queue: next-cycle check failed");
`else
`define SPQ_ASSERT_IMP(label, ante, cons)
`define SPQ_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- src/spq_pkg.sv -----
package spq_pkg;

    localparam int unsigned DATA_W       = 32;
    localparam int unsigned PRI_W        = 16;
    localparam int unsigned OCC_W        = 5;
    localparam int unsigned CAPACITY_DEF = 16;

    // Operation codes
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // One stored entry
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [PRI_W-1:0]  prio;
    } entry_t;

    // One result beat
    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] value;
        logic signed [PRI_W-1:0]  prio;
        logic [OCC_W-1:0]         occ;
    } result_t;

endpackage

// ----- src/spq_ram.sv -----
module spq_ram #(
    parameter int unsigned WIDTH  = 48,
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/spq_seq.sv -----
module spq_seq #(
    parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF,
    localparam int unsigned IW = $clog2(CAPACITY),
    localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              func,
    input  logic signed [spq_pkg::DATA_W-1:0] data_value,
    input  logic signed [spq_pkg::PRI_W-1:0]  priority_req,
    output logic                              ram_we,
    output logic [IW-1:0]                     ram_waddr,
    output spq_pkg::entry_t                   ram_wdata,
    output logic [IW-1:0]                     ram_raddr,
    input  spq_pkg::entry_t                   ram_rdata,
    output logic                              res_valid,
    input  logic                              res_ready,
    output spq_pkg::result_t                  res
);

    import spq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ_CMP,
        S_ENQ_HEAD,
        S_DEQ_RD,
        S_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] idx_reg, idx_next;
    entry_t        new_reg, new_next;
    result_t       res_reg, res_next;
    logic [CW-1:0] tail;
    logic [IW-1:0] idx_inc;
    logic [IW-1:0] idx_dec;
    logic          moves_down;

    assign tail       = count_reg - CW'(1);
    assign idx_inc    = idx_reg + IW'(1);
    assign idx_dec    = idx_reg - IW'(1);
    // Shared compare: the stored entry moves down if it ranks below the new one
    assign moves_down = $signed(ram_rdata.prio) < $signed(new_reg.prio);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // Sequence one item: an enqueue walks from the tail toward the head, one slot a cycle; a dequeue pops the tail
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        new_next   = new_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = idx_inc;
        ram_wdata  = new_reg;
        ram_raddr  = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    new_next.value = data_value;
                    new_next.prio  = priority_req;
                    res_next.status = ST_OK;
                    res_next.value  = '0;
                    res_next.prio   = '0;
                    if (func == FUNC_ENQ)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            res_next.status = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            ram_we          = 1'b1;
                            ram_waddr       = '0;
                            ram_wdata.value = data_value;
                            ram_wdata.prio  = priority_req;
                            count_next      = count_reg + CW'(1);
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            ram_raddr  = tail[IW-1:0];
                            idx_next   = tail[IW-1:0];
                            state_next = S_ENQ_CMP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = ST_EMPTY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            ram_raddr  = tail[IW-1:0];
                            state_next = S_DEQ_RD;
                        end
                    end
                end
            end

            S_ENQ_CMP:
            begin
                ram_we = 1'b1;
                if (moves_down)
                begin
                    // Shift the stored entry one slot toward the tail
                    ram_wdata = ram_rdata;
                    if (idx_reg == '0)
                    begin
                        state_next = S_ENQ_HEAD;
                    end
                    else
                    begin
                        idx_next  = idx_dec;
                        ram_raddr = idx_dec;
                    end
                end
                else
                begin
                    // Drop the new entry in behind this one
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end
            end

            S_ENQ_HEAD:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end

            S_DEQ_RD:
            begin
                res_next.value = ram_rdata.value;
                res_next.prio  = ram_rdata.prio;
                count_next     = tail;
                state_next     = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Capture the occupancy when the result is formed
        if ((state_next == S_DONE) && (state_reg != S_DONE))
        begin
            res_next.occ = OCC_W'(count_next);
        end
    end

    // Hold state, count and walk index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload holds need no reset
    always_ff @(posedge clk)
    begin
        new_reg <= new_next;
        res_reg <= res_next;
    end

endmodule

// ----- src/sorted_priority_queue.sv -----
// Sorted insertion priority queue, one item at a time, entries in a one-read one-write RAM.
// An enqueue walks from the tail toward the head (one RAM read, compare and write per slot),
// moving each lower-priority entry one slot toward the tail; a dequeue pops the tail entry;
// full, empty, or an enqueue into an empty queue ends without a walk. Each result passes an output
// register, and the sequencer accepts no new item until its result has entered that register.
// Reset (rst_n low, asynchronous) empties the queue; the RAM contents are not cleared.
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue #(
    parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              func,
    input  logic signed [spq_pkg::DATA_W-1:0] data_value,
    input  logic signed [spq_pkg::PRI_W-1:0]  priority_req,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic signed [spq_pkg::DATA_W-1:0] out_value,
    output logic signed [spq_pkg::PRI_W-1:0]  out_priority,
    output logic [spq_pkg::OCC_W-1:0]         occupancy
);

    import spq_pkg::*;

    localparam int unsigned IW = $clog2(CAPACITY);
    localparam int unsigned EW = $bits(entry_t);

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [IW-1:0] ram_raddr;
    entry_t        ram_wdata;
    entry_t        ram_rdata;
    logic          res_valid;
    logic          res_ready;
    result_t       res;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg;

    spq_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .data_value   (data_value),
        .priority_req (priority_req),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    spq_ram #(
        .WIDTH  (EW),
        .DEPTH  (CAPACITY),
        .ADDR_W (IW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register parts the sequencer from the result channel
    assign res_ready      = !out_valid_reg || out_ready;
    assign out_valid_next = res_valid || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load a finished result beat when the slot is free
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_reg.status;
    assign out_value    = out_reg.value;
    assign out_priority = out_reg.prio;
    assign occupancy    = out_reg.occ;

    `SPQ_ASSERT_IMP(a_full_occ, out_valid && (status == ST_FULL), occupancy == OCC_W'(CAPACITY))
    `SPQ_ASSERT_IMP(a_empty_zero, out_valid && (status == ST_EMPTY), {occupancy, out_value} == '0)
    `SPQ_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

// ----- tb/tb_sorted_priority_queue.sv -----
module tb_sorted_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int unsigned QDEPTH        = CAPACITY_DEF;
    localparam int unsigned RAND_PHASES   = 5;
    localparam int unsigned RAND_PER_PHASE = 285;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned SETTLE_CYCLES = QDEPTH + 12;
    localparam int unsigned N_DIRECTED    = 25;

    // One directed stimulus row; fixed_res is used when has_fixed is set
    typedef struct packed {
        logic              func;
        logic [DATA_W-1:0] value;
        logic [PRI_W-1:0]  prio;
        logic              has_fixed;
        result_t           fixed_res;
    } dir_row_t;

    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        '{FUNC_DEQ, 32'h0000_0000, 16'h0000, 1'b1, '{ST_EMPTY, 32'h0, 16'h0, 5'd0}},
        '{FUNC_ENQ, 32'h7FFF_FFFF, 16'h7FFF, 1'b1, '{ST_OK, 32'h0, 16'h0, 5'd1}},
        '{FUNC_ENQ, 32'h8000_0000, 16'h8000, 1'b1, '{ST_OK, 32'h0, 16'h0, 5'd2}},
        '{FUNC_DEQ, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
          '{ST_OK, 32'h8000_0000, 16'h8000, 5'd1}},
        '{FUNC_DEQ, 32'h0000_0000, 16'h0000, 1'b1,
          '{ST_OK, 32'h7FFF_FFFF, 16'h7FFF, 5'd0}},
        '{FUNC_DEQ, 32'hAAAA_AAAA, 16'h5555, 1'b1, '{ST_EMPTY, 32'h0, 16'h0, 5'd0}},
        // fill to capacity with ties at several priorities
        '{FUNC_ENQ, 32'h0000_0001, 16'h0005, 1'b0, '0},
        '{FUNC_ENQ, 32'h0000_0002, 16'h0005, 1'b0, '0},
        '{FUNC_ENQ, 32'hFFFF_FFFD, 16'hFFFD, 1'b0, '0},
        '{FUNC_ENQ, 32'h0000_0004, 16'h7FFF, 1'b0, '0},
        '{FUNC_ENQ, 32'h0000_0005, 16'h0005, 1'b0, '0},
        '{FUNC_ENQ, 32'h5555_AAAA, 16'h8000, 1'b0, '0},
        '{FUNC_ENQ, 32'h0000_0007, 16'h0000, 1'b0, '0},
        '{FUNC_ENQ, 32'h0000_0008, 16'h0000, 1'b0, '0},
        '{FUNC_ENQ, 32'hAAAA_5555, 16'h0064, 1'b0, '0},
        '{FUNC_ENQ, 32'h0000_000A, 16'hFFFD, 1'b0, '0},
        '{FUNC_ENQ, 32'h0000_000B, 16'h0005, 1'b0, '0},
        '{FUNC_ENQ, 32'h0000_000C, 16'h0001, 1'b0, '0},
        '{FUNC_ENQ, 32'h0000_000D, 16'h0001, 1'b0, '0},
        '{FUNC_ENQ, 32'h0000_000E, 16'hFFFF, 1'b0, '0},
        '{FUNC_ENQ, 32'h7FFF_FFFF, 16'h7FFF, 1'b0, '0},
        '{FUNC_ENQ, 32'h8000_0000, 16'h8000, 1'b0, '0},
        // refused even at top priority
        '{FUNC_ENQ, 32'h1234_5678, 16'h7FFF, 1'b1, '{ST_FULL, 32'h0, 16'h0, 5'd16}},
        '{FUNC_DEQ, 32'h0000_0000, 16'h0000, 1'b0, '0},
        '{FUNC_DEQ, 32'h0000_0000, 16'h0000, 1'b0, '0}
    };

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     func = FUNC_ENQ;
    logic signed [DATA_W-1:0] data_value = '0;
    logic signed [PRI_W-1:0]  priority_req = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] out_value;
    logic signed [PRI_W-1:0]  out_priority;
    logic [OCC_W-1:0]         occupancy;

    // Shadow copy of the sorted store, slot 0 is the head
    logic signed [DATA_W-1:0] shadow_value [QDEPTH];
    logic signed [PRI_W-1:0]  shadow_prio  [QDEPTH];
    int unsigned              shadow_count;

    result_t     results_due [$];
    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned beats_in;
    int unsigned popped_count;
    int unsigned full_count = 0;
    int unsigned empty_count = 0;

    sorted_priority_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .data_value   (data_value),
        .priority_req (priority_req),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_value    (out_value),
        .out_priority (out_priority),
        .occupancy    (occupancy)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Insert behind equal-or-higher priorities, or pop the tail
    function automatic result_t next_queue_result(input logic f,
                                                  input logic signed [DATA_W-1:0] v,
                                                  input logic signed [PRI_W-1:0] p);
        result_t     r;
        int unsigned pos;
        r = '0;
        r.status = ST_OK;
        if (f == FUNC_ENQ)
        begin
            if (shadow_count >= QDEPTH)
                r.status = ST_FULL;
            else
            begin
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] >= p)
                    pos++;
                for (int i = shadow_count; i > pos; i--)
                begin
                    shadow_value[i] = shadow_value[i-1];
                    shadow_prio[i]  = shadow_prio[i-1];
                end
                shadow_value[pos] = v;
                shadow_prio[pos]  = p;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
                r.status = ST_EMPTY;
            else
            begin
                shadow_count--;
                r.value = shadow_value[shadow_count];
                r.prio  = shadow_prio[shadow_count];
            end
        end
        r.occ = shadow_count[OCC_W-1:0];
        return r;
    endfunction

    // Drive one input beat, hold it until accepted, then record its expected result
    task automatic send_beat(input logic f, input logic [DATA_W-1:0] v,
                             input logic [PRI_W-1:0] p, input logic has_fixed,
                             input result_t fixed_res);
        result_t predicted;
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        data_value   <= v;
        priority_req <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = next_queue_result(f, v, p);
        results_due.push_back(has_fixed ? fixed_res : predicted);
        if (f == FUNC_DEQ && predicted.status == ST_OK)
            popped_count++;
        beats_in++;
    endtask

    // Drop valid and hold off until every result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_result_beat();
        result_t want;
        if (results_due.size() == 0)
        begin
            $error("result beat with nothing pending: status %0d value %0h", status, out_value);
            error_count++;
        end
        else
        begin
            want = results_due.pop_front();
            if (status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, status);
                error_count++;
            end
            if (out_value !== want.value)
            begin
                $error("out_value: expected %0h, got %0h", want.value, out_value);
                error_count++;
            end
            if (out_priority !== want.prio)
            begin
                $error("out_priority: expected %0h, got %0h", want.prio, out_priority);
                error_count++;
            end
            if (occupancy !== want.occ)
            begin
                $error("occupancy: expected %0d, got %0d", want.occ, occupancy);
                error_count++;
            end
            case (want.status)
                ST_FULL:  full_count++;
                ST_EMPTY: empty_count++;
                default:  ;
            endcase
        end
    endtask

    // Check result beats and stall the output at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            check_result_beat();
        end
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned      n;
        int unsigned      burst_len;
        int unsigned      enq_pct;
        int unsigned      pick;
        logic             f;
        logic [PRI_W-1:0] p;

        shadow_count = 0;
        beats_in     = 0;
        popped_count = 0;
        idle_pct     = 0;
        stall_pct    = 0;

        // Hold reset before the first beat
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int r = 0; r < N_DIRECTED; r++)
            send_beat(DIRECTED[r].func, DIRECTED[r].value, DIRECTED[r].prio,
                      DIRECTED[r].has_fixed, DIRECTED[r].fixed_res);
        wait_drained();

        // Random bursts: filling, draining or mixed, under each idling pattern
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 82; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 82; end
                3: begin idle_pct = 26; stall_pct = 26; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            n = 0;
            while (n < RAND_PER_PHASE)
            begin
                case ($urandom_range(2))
                    0:       enq_pct = 85;
                    1:       enq_pct = 15;
                    default: enq_pct = 55;
                endcase
                burst_len = $urandom_range(40, 8);
                for (int b = 0; b < burst_len && n < RAND_PER_PHASE; b++)
                begin
                    f    = ($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
                    pick = $urandom_range(99);
                    if (pick < 50)
                        p = PRI_W'($urandom_range(4)) - PRI_W'(2);
                    else if (pick < 65)
                    begin
                        case ($urandom_range(3))
                            0:       p = 16'h8000;
                            1:       p = 16'h7FFF;
                            2:       p = 16'hFFFF;
                            default: p = 16'h0000;
                        endcase
                    end
                    else
                        p = PRI_W'($urandom);
                    send_beat(f, DATA_W'($urandom), p, 1'b0, '0);
                    n++;
                end
            end
            wait_drained();
        end

        // Let any stray beat show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d queue operations in %0d cycles under four idling patterns,",
                 beats_in, cycle_count);
        $display("%0d entries popped, %0d enqueues refused as full, %0d dequeues hit empty.",
                 popped_count, full_count, empty_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
